// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CHECK_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked check that also runs during reset.
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/jcs_pkg.sv -----
// Shared types and constants of the comment stripper.
package jcs_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;

    localparam int OUT_DEPTH_DEF = 4;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t kept_byte;
        logic  byte_valid;
        logic  end_of_run;
    } result_t;

    // Pending-skip tracking inside comments.
    typedef enum logic [3:0] {
        SKIP_NONE   = 4'b0001,
        SKIP_BSL    = 4'b0010,
        SKIP_BSL_CR = 4'b0100,
        SKIP_STAR   = 4'b1000
    } skip_t;

    typedef struct packed {
        logic in_string;
        logic in_line_comment;
        logic in_block_comment;
        logic held_valid;
    } flt_status_t;

    typedef struct packed {
        logic room;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/jcs_filter.sv -----
// Comment filter: mode flags, slash lookahead and per-word decision.
module jcs_filter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  jcs_pkg::byte_t    text_byte,
    input  logic              end_of_text,
    output jcs_pkg::result_t  res0,
    output jcs_pkg::result_t  res1,
    output logic [1:0]        push_count,
    output jcs_pkg::flt_status_t status
);
    import jcs_pkg::*;

    logic  str_reg, str_next;
    logic  line_reg, line_next;
    logic  blk_reg, blk_next;
    logic  held_reg, held_next;
    skip_t skip_reg, skip_next;
    logic  done;
    logic  fresh;
    logic [1:0] cnt;

    always_comb
    begin
        str_next  = str_reg;
        line_next = line_reg;
        blk_next  = blk_reg;
        held_next = held_reg;
        skip_next = skip_reg;
        done      = 1'b0;
        fresh     = 1'b0;
        cnt       = 2'd0;
        res0      = '0;
        res1      = '0;

        if (line_reg)
        begin
            if (skip_reg == SKIP_BSL_CR)
            begin
                skip_next = SKIP_NONE;
                done      = (text_byte == CH_LF);
            end
            else if (skip_reg == SKIP_BSL)
            begin
                done = 1'b1;
                if (text_byte == CH_CR)
                    skip_next = SKIP_BSL_CR;
                else if (text_byte == CH_BSLASH)
                    skip_next = SKIP_BSL;
                else
                    skip_next = SKIP_NONE;
            end
            if (!done)
            begin
                skip_next = SKIP_NONE;
                if (text_byte == CH_CR || text_byte == CH_LF)
                    line_next = 1'b0;
                else if (text_byte == CH_BSLASH)
                    skip_next = SKIP_BSL;
            end
        end
        else if (blk_reg)
        begin
            if (skip_reg == SKIP_STAR && text_byte == CH_SLASH)
            begin
                blk_next  = 1'b0;
                skip_next = SKIP_NONE;
            end
            else
                skip_next = (text_byte == CH_STAR) ? SKIP_STAR : SKIP_NONE;
        end
        else if (held_reg)
        begin
            held_next = 1'b0;
            skip_next = SKIP_NONE;
            if (text_byte == CH_SLASH)
                line_next = 1'b1;
            else if (text_byte == CH_STAR)
                blk_next = 1'b1;
            else
            begin
                // release the held slash ahead of this word
                res0  = '{kept_byte: CH_SLASH, byte_valid: 1'b1, end_of_run: 1'b0};
                cnt   = 2'd1;
                fresh = 1'b1;
            end
        end
        else
        begin
            skip_next = SKIP_NONE;
            fresh     = 1'b1;
        end

        if (fresh)
        begin
            if (!str_reg && text_byte == CH_SLASH)
                held_next = 1'b1;
            else
            begin
                if (text_byte == CH_QUOTE)
                    str_next = !str_reg;
                if (cnt == 2'd0)
                    res0 = '{kept_byte: text_byte, byte_valid: 1'b1, end_of_run: 1'b0};
                else
                    res1 = '{kept_byte: text_byte, byte_valid: 1'b1, end_of_run: 1'b0};
                cnt = cnt + 2'd1;
            end
        end

        if (end_of_text)
        begin
            // flush lookahead, emit empty marker if nothing else goes out
            if (held_next)
            begin
                if (cnt == 2'd0)
                    res0 = '{kept_byte: CH_SLASH, byte_valid: 1'b1, end_of_run: 1'b0};
                else
                    res1 = '{kept_byte: CH_SLASH, byte_valid: 1'b1, end_of_run: 1'b0};
                cnt = cnt + 2'd1;
            end
            if (cnt == 2'd0)
            begin
                res0 = '0;
                cnt  = 2'd1;
            end
            if (cnt == 2'd1)
                res0.end_of_run = 1'b1;
            else
                res1.end_of_run = 1'b1;
            str_next  = 1'b0;
            line_next = 1'b0;
            blk_next  = 1'b0;
            held_next = 1'b0;
            skip_next = SKIP_NONE;
        end
    end

    assign push_count = take ? cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            str_reg  <= 1'b0;
            line_reg <= 1'b0;
            blk_reg  <= 1'b0;
            held_reg <= 1'b0;
            skip_reg <= SKIP_NONE;
        end
        else if (take)
        begin
            str_reg  <= str_next;
            line_reg <= line_next;
            blk_reg  <= blk_next;
            held_reg <= held_next;
            skip_reg <= skip_next;
        end
    end

    assign status = '{in_string: str_reg, in_line_comment: line_reg,
                      in_block_comment: blk_reg, held_valid: held_reg};

endmodule

// ----- sv/jcs_out_queue.sv -----
// Result queue: takes up to two words a cycle, delivers one unless out_stall.
module jcs_out_queue #(
    parameter int DEPTH = jcs_pkg::OUT_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  jcs_pkg::result_t           push0,
    input  jcs_pkg::result_t           push1,
    input  logic [1:0]                 push_count,
    input  logic                       out_stall,
    output logic                       out_valid,
    output jcs_pkg::result_t           head,
    output jcs_pkg::q_status_t         status,
    output logic [$clog2(DEPTH+1)-1:0] fill_count
);
    import jcs_pkg::*;

    // DEPTH: power of two, at least 2
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign pop          = (count_reg != '0) && !out_stall;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push_count);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign count_next   = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid  = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign fill_count = count_reg;
    assign status     = '{room: (count_reg <= CNT_W'(DEPTH - 2)), empty: (count_reg == '0)};

endmodule

// ----- sv/json_comment_stripper.sv -----
// Top level of the comment stripper: input register, filter, result queue.
// Strips // and /* */ comments from a byte stream, one input word per clock.
// A word goes from the input register through the filter into a small result
// queue; its first result shows on out_valid once the queue has taken it, which
// waits while the queue lacks room. Most words yield one result. A held slash
// released ahead of the next byte yields two; one flushed at end_of_text yields
// one. The output port delivers one word a cycle unless out_stall, so a run of
// such words is paced by that port. The input stalls only when the queue has
// fewer than two free entries (queue depth OUT_DEPTH).
module json_comment_stripper #(
    parameter int OUT_DEPTH = jcs_pkg::OUT_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  jcs_pkg::byte_t text_byte,
    input  logic           end_of_text,
    output logic           out_valid,
    input  logic           out_stall,
    output jcs_pkg::byte_t kept_byte,
    output logic           byte_valid,
    output logic           end_of_run
);
    import jcs_pkg::*;

    `include "assert_macros.svh"

    logic        stage_valid_reg, stage_valid_next;
    byte_t       stage_byte_reg;
    logic        stage_last_reg;
    logic        take;
    logic        accept;
    result_t     res0, res1, head;
    logic [1:0]  push_count;
    flt_status_t flt_status;
    q_status_t   q_status;
    logic [$clog2(OUT_DEPTH+1)-1:0] fill_count;

    assign take     = stage_valid_reg && q_status.room;
    assign in_stall = stage_valid_reg && !q_status.room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (take)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= text_byte;
            stage_last_reg <= end_of_text;
        end
    end

    jcs_filter u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .text_byte   (stage_byte_reg),
        .end_of_text (stage_last_reg),
        .res0        (res0),
        .res1        (res1),
        .push_count  (push_count),
        .status      (flt_status)
    );

    jcs_out_queue #(
        .DEPTH (OUT_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (res0),
        .push1      (res1),
        .push_count (push_count),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .head       (head),
        .status     (q_status),
        .fill_count (fill_count)
    );

    assign kept_byte  = head.kept_byte;
    assign byte_valid = head.byte_valid;
    assign end_of_run = head.end_of_run;

    `CHECK_CLK(a_fill_bound, fill_count <= ($clog2(OUT_DEPTH+1))'(OUT_DEPTH), "queue overfilled")
    `CHECK_CLK(a_take_emits, take && stage_last_reg |-> push_count != 2'd0, "end word lost")
    `CHECK_CLK(a_end_clears, take && stage_last_reg |=> flt_status == '0, "state not cleared")
    `CHECK_CLK(a_one_comment, !(flt_status.in_line_comment && flt_status.in_block_comment), "two comment modes")

endmodule

// ----- verif/json_comment_stripper_tb.sv -----
// Self-checking testbench for json_comment_stripper: directed table, random texts, predictor.
module json_comment_stripper_tb;
    import jcs_pkg::*;

    localparam int STUCK_LIMIT = 1000;
    localparam int RAND_ITEMS  = 900;
    localparam int DRAIN_CYCLES = 10;

    // One stimulus word; typed rows carry their own expected results.
    typedef struct packed {
        byte_t     b;
        logic      last;
        logic      typed;
        logic [1:0] n;
        result_t   r0;
        result_t   r1;
    } row_t;

    localparam result_t NO_RES = '0;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    byte_t text_byte;
    logic  end_of_text;
    logic  out_valid;
    logic  out_stall;
    byte_t kept_byte;
    logic  byte_valid;
    logic  end_of_run;

    json_comment_stripper u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kept_byte  (kept_byte),
        .byte_valid (byte_valid),
        .end_of_run (end_of_run)
    );

    row_t    stim_q[$];
    result_t kept_q[$];
    int      idx;
    int      stuck;
    int      errors;
    logic    calm;

    // Filter state mirrored by the predictor
    logic  st_in_string;
    logic  st_line;
    logic  st_block;
    logic  st_held;
    skip_t st_skip;

    assign calm = (idx >= 300 && idx < 500);

    task automatic clear_filter();
        st_in_string = 1'b0;
        st_line      = 1'b0;
        st_block     = 1'b0;
        st_held      = 1'b0;
        st_skip      = SKIP_NONE;
    endtask

    // Byte seen outside any comment with nothing held.
    task automatic pass_plain(input byte_t b, ref result_t outq[$]);
        if (!st_in_string && b == CH_SLASH)
            st_held = 1'b1;
        else
        begin
            if (b == CH_QUOTE)
                st_in_string = ~st_in_string;
            outq.push_back({b, 1'b1, 1'b0});
        end
    endtask

    task automatic strip_predict(input byte_t b, input logic last, ref result_t outq[$]);
        logic done;
        done = 1'b0;
        if (st_line)
        begin
            if (st_skip == SKIP_BSL_CR)
            begin
                st_skip = SKIP_NONE;
                if (b == CH_LF)
                    done = 1'b1;
            end
            else if (st_skip == SKIP_BSL)
            begin
                if (b == CH_CR)
                    st_skip = SKIP_BSL_CR;
                else if (b == CH_BSLASH)
                    st_skip = SKIP_BSL;
                else
                    st_skip = SKIP_NONE;
                done = 1'b1;
            end
            if (!done)
            begin
                st_skip = SKIP_NONE;
                if (b == CH_CR || b == CH_LF)
                    st_line = 1'b0;
                else if (b == CH_BSLASH)
                    st_skip = SKIP_BSL;
            end
        end
        else if (st_block)
        begin
            if (st_skip == SKIP_STAR && b == CH_SLASH)
            begin
                st_block = 1'b0;
                st_skip  = SKIP_NONE;
            end
            else
                st_skip = (b == CH_STAR) ? SKIP_STAR : SKIP_NONE;
        end
        else if (st_held)
        begin
            st_held = 1'b0;
            st_skip = SKIP_NONE;
            if (b == CH_SLASH)
                st_line = 1'b1;
            else if (b == CH_STAR)
                st_block = 1'b1;
            else
            begin
                outq.push_back({CH_SLASH, 1'b1, 1'b0});
                pass_plain(b, outq);
            end
        end
        else
        begin
            st_skip = SKIP_NONE;
            pass_plain(b, outq);
        end
        if (last)
        begin
            if (st_held)
                outq.push_back({CH_SLASH, 1'b1, 1'b0});
            if (outq.size() == 0)
                outq.push_back({8'h00, 1'b0, 1'b0});
            outq[outq.size() - 1].end_of_run = 1'b1;
            clear_filter();
        end
    endtask

    // Mostly the characters that steer the filter, some letters, some raw bytes.
    function automatic byte_t pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return CH_SLASH;
        else if (r < 27)
            return CH_STAR;
        else if (r < 35)
            return CH_QUOTE;
        else if (r < 43)
            return CH_BSLASH;
        else if (r < 51)
            return CH_CR;
        else if (r < 59)
            return CH_LF;
        else if (r < 85)
            return byte_t'(8'h61 + $urandom_range(0, 25));
        else
            return byte_t'($urandom_range(0, 255));
    endfunction

    // One text: comments, strings and noise, closed by end_of_text.
    task automatic gen_text(ref byte_t txt[$]);
        int segs;
        int kind;
        int len;
        txt = {};
        segs = $urandom_range(1, 6);
        for (int s = 0; s < segs; s++)
        begin
            kind = $urandom_range(0, 9);
            len = $urandom_range(0, 6);
            if (kind < 2)
            begin
                txt.push_back(CH_SLASH);
                txt.push_back(CH_SLASH);
                for (int i = 0; i < len; i++)
                    txt.push_back(pick_char());
                if ($urandom_range(0, 3) == 0)
                begin
                    txt.push_back(CH_BSLASH);
                    if ($urandom_range(0, 1))
                        txt.push_back(CH_CR);
                    txt.push_back(CH_LF);
                    txt.push_back(pick_char());
                end
                case ($urandom_range(0, 2))
                    0: txt.push_back(CH_CR);
                    1: txt.push_back(CH_LF);
                    default:
                    begin
                        txt.push_back(CH_CR);
                        txt.push_back(CH_LF);
                    end
                endcase
            end
            else if (kind < 4)
            begin
                txt.push_back(CH_SLASH);
                txt.push_back(CH_STAR);
                for (int i = 0; i < len; i++)
                    txt.push_back(pick_char());
                txt.push_back(CH_STAR);
                txt.push_back(CH_SLASH);
            end
            else if (kind < 5)
            begin
                txt.push_back(CH_QUOTE);
                for (int i = 0; i < len; i++)
                    txt.push_back(pick_char());
                txt.push_back(CH_QUOTE);
            end
            else
            begin
                for (int i = 0; i <= len; i++)
                    txt.push_back(pick_char());
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input side: apply prediction on acceptance, then present next word or idle.
    always @(posedge clk)
    begin : drv
        row_t    row;
        result_t res_q[$];
        int      nxt;
        if (rst_n)
        begin
            nxt = idx;
            if (in_valid && !in_stall)
            begin
                row = stim_q[idx];
                res_q = {};
                strip_predict(row.b, row.last, res_q);
                if (row.typed)
                begin
                    kept_q.push_back(row.r0);
                    if (row.n == 2'd2)
                        kept_q.push_back(row.r1);
                end
                else
                    foreach (res_q[k])
                        kept_q.push_back(res_q[k]);
                nxt = idx + 1;
            end
            idx <= nxt;
            if (in_valid && in_stall)
                ;
            else if (nxt < stim_q.size() && (calm || $urandom_range(0, 99) >= 8))
            begin
                in_valid    <= 1'b1;
                text_byte   <= stim_q[nxt].b;
                end_of_text <= stim_q[nxt].last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: check each accepted word against the oldest expectation.
    always @(posedge clk)
    begin : chk
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (kept_q.size() == 0)
                begin
                    $display("%0t: unexpected word kept_byte=%h byte_valid=%b end_of_run=%b",
                             $time, kept_byte, byte_valid, end_of_run);
                    errors = errors + 1;
                end
                else
                begin
                    want = kept_q.pop_front();
                    if (kept_byte !== want.kept_byte || byte_valid !== want.byte_valid ||
                        end_of_run !== want.end_of_run)
                    begin
                        $display("%0t: mismatch expected kept_byte=%h byte_valid=%b end_of_run=%b",
                                 $time, want.kept_byte, want.byte_valid, want.end_of_run);
                        $display("%0t:          actual   kept_byte=%h byte_valid=%b end_of_run=%b",
                                 $time, kept_byte, byte_valid, end_of_run);
                        errors = errors + 1;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 8);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stuck <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck <= 0;
        else
            stuck <= stuck + 1;
    end

    initial
    begin : main
        row_t  dir_tab [26];
        byte_t txt[$];
        int    total;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        text_byte   = '0;
        end_of_text = 1'b0;
        out_stall   = 1'b0;
        idx         = 0;
        errors      = 0;
        clear_filter();

        dir_tab = '{
            '{8'h41,     1'b0, 1'b1, 2'd1, {8'h41, 1'b1, 1'b0}, NO_RES},
            '{8'h00,     1'b0, 1'b1, 2'd1, {8'h00, 1'b1, 1'b0}, NO_RES},
            '{8'hFF,     1'b0, 1'b1, 2'd1, {8'hFF, 1'b1, 1'b0}, NO_RES},
            // held slash released ahead of the next byte
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{8'h78,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            // line comment, backslash CR LF continuation, then lone-CR continuation
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_CR,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_LF,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{8'h63,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_CR,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{8'h78,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_LF,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            // slashes inside a string pass through
            '{CH_QUOTE,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_QUOTE,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            // block comment with a doubled star before the close
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            // held slash flushed at the end of text
            '{CH_SLASH,  1'b1, 1'b1, 2'd1, {CH_SLASH, 1'b1, 1'b1}, NO_RES},
            // end inside a comment gives the empty end marker
            '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{CH_SLASH,  1'b1, 1'b1, 2'd1, {8'h00, 1'b0, 1'b1}, NO_RES}
        };
        foreach (dir_tab[i])
            stim_q.push_back(dir_tab[i]);

        total = 0;
        while (total < RAND_ITEMS)
        begin
            gen_text(txt);
            foreach (txt[i])
                stim_q.push_back('{txt[i], (i == txt.size() - 1), 1'b0, 2'd0, NO_RES, NO_RES});
            total = total + txt.size();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(idx == stim_q.size() && kept_q.size() == 0) && stuck < STUCK_LIMIT)
            @(posedge clk);
        if (stuck < STUCK_LIMIT)
            repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && stuck < STUCK_LIMIT && kept_q.size() == 0)
            $display("json_comment_stripper_tb: PASS");
        else
            $display("json_comment_stripper_tb: FAIL");
        $finish;
    end

endmodule
